@@ sv/rsa_ped_pkg.sv @@
// Shared constants and types for the RSA private exponent derivation block.
package rsa_ped_pkg;

    localparam int PRIME_WIDTH = 16;
    localparam int WORD_WIDTH  = 32;
    localparam int CNT_WIDTH   = $clog2(WORD_WIDTH);

    localparam logic [WORD_WIDTH-1:0] EXP_MIN = 32'd3;

    typedef logic [WORD_WIDTH-1:0] word_t;
    typedef logic [1:0] status_t;

    localparam status_t ST_OK          = 2'd0;
    localparam status_t ST_PRIME_LOW   = 2'd1;
    localparam status_t ST_EXP_RANGE   = 2'd2;
    localparam status_t ST_NOT_COPRIME = 2'd3;

    typedef struct packed {
        logic  done;
        word_t quotient;
        word_t remainder;
    } div_rsp_t;

endpackage

@@ sv/rsa_ped_divider.sv @@
// Restoring radix-2 divider: one quotient bit per cycle.
module rsa_ped_divider
    import rsa_ped_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     start,
    input  word_t    dividend,
    input  word_t    divisor,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_WIDTH-1:0] cnt_reg, cnt_next;
    word_t                quo_reg, quo_next;
    word_t                rem_reg, rem_next;
    word_t                div_reg, div_next;
    logic [WORD_WIDTH:0]  rem_shift;
    logic [WORD_WIDTH:0]  rem_sub;
    logic                 fits;

    always_comb begin
        rem_shift = {rem_reg, quo_reg[WORD_WIDTH-1]};
        fits      = rem_shift >= {1'b0, div_reg};
        rem_sub   = rem_shift - {1'b0, div_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[WORD_WIDTH-2:0], fits};
            rem_next = fits ? rem_sub[WORD_WIDTH-1:0] : rem_shift[WORD_WIDTH-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_WIDTH'(WORD_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ sv/rsa_private_exponent_derivation.sv @@
// RSA key derivation: modulus, Carmichael lambda and private exponent via extended Euclid.
// One transaction at a time: s_ready is high only while idle. Every quotient and
// remainder comes from one shared restoring divider, and products from one
// registered 32x32 multiplier. How long a transaction takes from acceptance to the
// result depends on the data-dependent numbers of gcd and Euclid steps.
module rsa_private_exponent_derivation
    import rsa_ped_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [31:0]           s_public_exponent,
    input  logic [15:0]           s_prime_one,
    input  logic [15:0]           s_prime_two,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [31:0]           m_modulus,
    output logic [31:0]           m_carmichael_lambda,
    output logic [31:0]           m_private_exponent,
    output logic [1:0]            m_status
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_MULN  = 5'd1;
    localparam logic [4:0] S_CHK   = 5'd2;
    localparam logic [4:0] S_GCD_T = 5'd3;
    localparam logic [4:0] S_GCD_S = 5'd4;
    localparam logic [4:0] S_GCD_W = 5'd5;
    localparam logic [4:0] S_LAM_S = 5'd6;
    localparam logic [4:0] S_LAM_W = 5'd7;
    localparam logic [4:0] S_LAM_M = 5'd8;
    localparam logic [4:0] S_LAM_C = 5'd9;
    localparam logic [4:0] S_INV_S = 5'd10;
    localparam logic [4:0] S_INV_W = 5'd11;
    localparam logic [4:0] S_EUC_T = 5'd12;
    localparam logic [4:0] S_EUC_S = 5'd13;
    localparam logic [4:0] S_EUC_W = 5'd14;
    localparam logic [4:0] S_EUC_M = 5'd15;
    localparam logic [4:0] S_EUC_A = 5'd16;
    localparam logic [4:0] S_FIN   = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    logic [4:0]             state_reg, state_next;
    word_t                  e_reg, e_next;
    logic [PRIME_WIDTH-1:0] p_reg, p_next;
    logic [PRIME_WIDTH-1:0] q_reg, q_next;
    word_t                  n_reg, n_next;
    word_t                  lam_reg, lam_next;
    word_t                  a_reg, a_next;
    word_t                  b_reg, b_next;
    word_t                  qt_reg, qt_next;
    word_t                  t0_reg, t0_next;
    word_t                  t1_reg, t1_next;
    logic                   neg0_reg, neg0_next;
    logic                   neg1_reg, neg1_next;
    word_t                  d_reg, d_next;
    status_t                st_reg, st_next;
    word_t                  mul_reg;

    word_t                  mul_a, mul_b;
    word_t                  mul_full;
    word_t                  pm1, qm1, t0_red;
    logic                   div_start;
    word_t                  div_dividend, div_divisor;
    div_rsp_t               div_rsp;

    rsa_ped_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .rsp      (div_rsp)
    );

    // only the low word is ever needed
    assign mul_full = mul_a * mul_b;
    assign pm1      = WORD_WIDTH'(p_reg) - 1'b1;
    assign qm1      = WORD_WIDTH'(q_reg) - 1'b1;
    assign t0_red   = (t0_reg >= lam_reg) ? t0_reg - lam_reg : t0_reg;

    always_comb begin
        state_next   = state_reg;
        e_next       = e_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        n_next       = n_reg;
        lam_next     = lam_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        qt_next      = qt_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        neg0_next    = neg0_reg;
        neg1_next    = neg1_reg;
        d_next       = d_reg;
        st_next      = st_reg;
        mul_a        = qt_reg;
        mul_b        = t1_reg;
        div_start    = 1'b0;
        div_dividend = a_reg;
        div_divisor  = b_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    e_next     = s_public_exponent;
                    p_next     = s_prime_one[PRIME_WIDTH-1:0];
                    q_next     = s_prime_two[PRIME_WIDTH-1:0];
                    state_next = S_MULN;
                end
            end
            S_MULN: begin
                mul_a      = WORD_WIDTH'(p_reg);
                mul_b      = WORD_WIDTH'(q_reg);
                state_next = S_CHK;
            end
            S_CHK: begin
                n_next = mul_reg;
                if (p_reg < PRIME_WIDTH'(2) || q_reg < PRIME_WIDTH'(2)) begin
                    st_next    = ST_PRIME_LOW;
                    lam_next   = '0;
                    d_next     = '0;
                    state_next = S_OUT;
                end else begin
                    a_next     = pm1;
                    b_next     = qm1;
                    state_next = S_GCD_T;
                end
            end
            S_GCD_T: begin
                state_next = (b_reg == '0) ? S_LAM_S : S_GCD_S;
            end
            S_GCD_S: begin
                div_start  = 1'b1;
                state_next = S_GCD_W;
            end
            S_GCD_W: begin
                if (div_rsp.done) begin
                    a_next     = b_reg;
                    b_next     = div_rsp.remainder;
                    state_next = S_GCD_T;
                end
            end
            S_LAM_S: begin
                // a_reg holds gcd(p-1, q-1)
                div_start    = 1'b1;
                div_dividend = pm1;
                div_divisor  = a_reg;
                state_next   = S_LAM_W;
            end
            S_LAM_W: begin
                if (div_rsp.done) begin
                    qt_next    = div_rsp.quotient;
                    state_next = S_LAM_M;
                end
            end
            S_LAM_M: begin
                mul_a      = qt_reg;
                mul_b      = qm1;
                state_next = S_LAM_C;
            end
            S_LAM_C: begin
                lam_next = mul_reg;
                // n >= 4 here, so e > n-1 is e >= n
                if (e_reg < EXP_MIN || e_reg >= n_reg) begin
                    st_next    = ST_EXP_RANGE;
                    d_next     = '0;
                    state_next = S_OUT;
                end else begin
                    state_next = S_INV_S;
                end
            end
            S_INV_S: begin
                div_start    = 1'b1;
                div_dividend = e_reg;
                div_divisor  = lam_reg;
                state_next   = S_INV_W;
            end
            S_INV_W: begin
                if (div_rsp.done) begin
                    a_next     = lam_reg;
                    b_next     = div_rsp.remainder;
                    t0_next    = '0;
                    t1_next    = WORD_WIDTH'(1);
                    neg0_next  = 1'b0;
                    neg1_next  = 1'b0;
                    state_next = S_EUC_T;
                end
            end
            S_EUC_T: begin
                state_next = (b_reg == '0) ? S_FIN : S_EUC_S;
            end
            S_EUC_S: begin
                div_start  = 1'b1;
                state_next = S_EUC_W;
            end
            S_EUC_W: begin
                if (div_rsp.done) begin
                    qt_next    = div_rsp.quotient;
                    a_next     = b_reg;
                    b_next     = div_rsp.remainder;
                    state_next = S_EUC_M;
                end
            end
            S_EUC_M: begin
                state_next = S_EUC_A;
            end
            S_EUC_A: begin
                // coefficient signs alternate, so magnitudes add
                t0_next    = t1_reg;
                t1_next    = t0_reg + mul_reg;
                neg0_next  = neg1_reg;
                neg1_next  = !neg1_reg;
                state_next = S_EUC_T;
            end
            S_FIN: begin
                if (a_reg != WORD_WIDTH'(1)) begin
                    st_next = ST_NOT_COPRIME;
                    d_next  = '0;
                end else begin
                    st_next = ST_OK;
                    d_next  = (neg0_reg && t0_red != '0) ? lam_reg - t0_red : t0_red;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        e_reg    <= e_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        n_reg    <= n_next;
        lam_reg  <= lam_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        qt_reg   <= qt_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        neg0_reg <= neg0_next;
        neg1_reg <= neg1_next;
        d_reg    <= d_next;
        st_reg   <= st_next;
        mul_reg  <= mul_full;
    end

    assign s_ready             = (state_reg == S_IDLE);
    assign m_valid             = (state_reg == S_OUT);
    assign m_modulus           = n_reg;
    assign m_carmichael_lambda = lam_reg;
    assign m_private_exponent  = d_reg;
    assign m_status            = st_reg;

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the RSA private exponent derivation block.
`timescale 1ns / 100ps

module tb;
    import rsa_ped_pkg::*;

    localparam int N_RANDOM   = 300;
    localparam int STALL_MAX  = 200000;
    localparam int N_DIRECTED = 20;

    typedef struct packed {
        word_t   modulus;
        word_t   lambda;
        word_t   priv_exp;
        status_t status;
    } key_t;

    typedef struct {
        logic [31:0] e;
        logic [15:0] p;
        logic [15:0] q;
        bit          known;
        key_t        key;
    } vec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_public_exponent = '0;
    logic [15:0] s_prime_one = '0;
    logic [15:0] s_prime_two = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_modulus;
    logic [31:0] m_carmichael_lambda;
    logic [31:0] m_private_exponent;
    logic [1:0]  m_status;

    key_t  pending_keys[$];
    int    mismatches = 0;
    int    results_seen = 0;
    int    stall_cycles = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    int    n_ok = 0, n_low = 0, n_range = 0, n_copr = 0;
    vec_t  directed[N_DIRECTED];

    always #5 aclk = ~aclk;

    rsa_private_exponent_derivation DUT (.*);

    function automatic longint unsigned gcd64(longint unsigned a, longint unsigned b);
        longint unsigned r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic key_t derive_key(logic [31:0] e_in, logic [15:0] p_in,
                                        logic [15:0] q_in);
        key_t k;
        longint unsigned e, p, q, n, lam, a, b, r0, r1, t0, t1, qt, rn, tn;
        bit neg0, neg1, negn;
        e = e_in;
        p = p_in;
        q = q_in;
        n = p * q;
        lam = 0;
        k.priv_exp = '0;
        if (p < 2 || q < 2) begin
            k.status = ST_PRIME_LOW;
        end else begin
            a = p - 1;
            b = q - 1;
            lam = (a / gcd64(a, b)) * b;
            if (e < 3 || e > n - 1) begin
                k.status = ST_EXP_RANGE;
            end else begin
                r0 = lam; r1 = e % lam;
                t0 = 0; t1 = 1; neg0 = 0; neg1 = 0;
                while (r1 != 0) begin
                    qt = r0 / r1;
                    rn = r0 - qt * r1;
                    tn = t0 + qt * t1;
                    negn = !neg1;
                    r0 = r1; r1 = rn;
                    t0 = t1; neg0 = neg1;
                    t1 = tn; neg1 = negn;
                end
                t0 = t0 % lam;
                if (r0 != 1) begin
                    k.status = ST_NOT_COPRIME;
                end else begin
                    k.status = ST_OK;
                    k.priv_exp = (neg0 && t0 != 0) ? word_t'(lam - t0) : word_t'(t0);
                end
            end
        end
        k.modulus = word_t'(n);
        k.lambda = word_t'(lam);
        return k;
    endfunction

    function automatic vec_t row(logic [31:0] e, logic [15:0] p, logic [15:0] q, bit known,
                                 word_t n, word_t lam, word_t d, status_t st);
        vec_t v;
        v.e = e; v.p = p; v.q = q; v.known = known;
        v.key.modulus = n; v.key.lambda = lam; v.key.priv_exp = d; v.key.status = st;
        return v;
    endfunction

    initial begin
        directed[0]  = row(32'd0, 16'd0, 16'd0, 1'b1, 0, 0, 0, ST_PRIME_LOW);
        directed[1]  = row(32'hFFFF_FFFF, 16'd1, 16'hFFFF, 1'b1, 32'hFFFF, 0, 0, ST_PRIME_LOW);
        directed[2]  = row(32'd65537, 16'hFFFF, 16'd0, 1'b1, 0, 0, 0, ST_PRIME_LOW);
        directed[3]  = row(32'd3, 16'd2, 16'd2, 1'b1, 4, 1, 0, ST_OK);
        directed[4]  = row(32'd2, 16'd2, 16'd2, 1'b1, 4, 1, 0, ST_EXP_RANGE);
        directed[5]  = row(32'd4, 16'd2, 16'd2, 1'b1, 4, 1, 0, ST_EXP_RANGE);
        directed[6]  = row(32'd3, 16'd5, 16'd7, 1'b1, 35, 12, 0, ST_NOT_COPRIME);
        directed[7]  = row(32'd5, 16'd5, 16'd7, 1'b1, 35, 12, 5, ST_OK);
        directed[8]  = row(32'd34, 16'd5, 16'd7, 1'b0, 0, 0, 0, ST_OK);
        directed[9]  = row(32'd35, 16'd5, 16'd7, 1'b1, 35, 12, 0, ST_EXP_RANGE);
        directed[10] = row(32'd17, 16'd61, 16'd53, 1'b0, 0, 0, 0, ST_OK);
        directed[11] = row(32'd65537, 16'd65521, 16'd65519, 1'b0, 0, 0, 0, ST_OK);
        directed[12] = row(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 0, 0, 0, ST_OK);
        directed[13] = row(32'hFFFE_0000, 16'hFFFF, 16'hFFFF, 1'b0, 0, 0, 0, ST_OK);
        directed[14] = row(32'd3, 16'd3, 16'd3, 1'b0, 0, 0, 0, ST_OK);
        directed[15] = row(32'd65537, 16'd65521, 16'd2, 1'b0, 0, 0, 0, ST_OK);
        directed[16] = row(32'hAAAA_5555, 16'hAAAA, 16'h5555, 1'b0, 0, 0, 0, ST_OK);
        directed[17] = row(32'h5555_AAAA, 16'h5555, 16'hAAAA, 1'b0, 0, 0, 0, ST_OK);
        directed[18] = row(32'd7, 16'd3, 16'd5, 1'b0, 0, 0, 0, ST_OK);
        directed[19] = row(32'd1, 16'd0, 16'd1, 1'b1, 0, 0, 0, ST_PRIME_LOW);
    end

    // s_valid stays high between back-to-back transactions; it drops only while idling or draining
    task automatic send_item(logic [31:0] e, logic [15:0] p, logic [15:0] q,
                             bit known, key_t kn);
        key_t k;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        k = known ? kn : derive_key(e, p, q);
        if (known && k != derive_key(e, p, q))
            $display("note: table row for e=%0d p=%0d q=%0d disagrees with predictor", e, p, q);
        s_valid <= 1'b1;
        s_public_exponent <= e;
        s_prime_one <= p;
        s_prime_two <= q;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_keys.push_back(k);
        case (k.status)
            ST_OK:        n_ok++;
            ST_PRIME_LOW: n_low++;
            ST_EXP_RANGE: n_range++;
            default:      n_copr++;
        endcase
    endtask

    // Mostly prime-like odd factors; occasional tiny or raw values.
    function automatic logic [15:0] rand_prime();
        int sel;
        sel = $urandom_range(9);
        if (sel == 0) return 16'($urandom_range(3));
        if (sel == 1) return 16'($urandom);
        if (sel < 5) return 16'($urandom_range(255) | 1);
        return 16'($urandom | 1);
    endfunction

    task automatic send_random();
        logic [15:0] p, q;
        logic [31:0] e;
        longint unsigned n;
        p = rand_prime();
        q = rand_prime();
        n = longint'(p) * longint'(q);
        case ($urandom_range(7))
            0:       e = $urandom;
            1:       e = 32'($urandom_range(4));
            2:       e = (n > 0) ? 32'(n - 1 + $urandom_range(1)) : 32'd0;
            3:       e = 32'd65537;
            default: e = (n > 3) ? 32'(3 + ({$urandom, $urandom} % (n - 3))) | 1 : 32'd3;
        endcase
        send_item(e, p, q, 1'b0, '{default: '0});
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                key_t want;
                results_seen++;
                if (pending_keys.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("ERROR: unexpected result n=%0d", m_modulus);
                end else begin
                    want = pending_keys.pop_front();
                    if (m_modulus !== want.modulus || m_carmichael_lambda !== want.lambda ||
                        m_private_exponent !== want.priv_exp || m_status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: got n=%0d lam=%0d d=%0d st=%0d, exp n=%0d lam=%0d d=%0d st=%0d",
                                     m_modulus, m_carmichael_lambda, m_private_exponent, m_status,
                                     want.modulus, want.lambda, want.priv_exp, want.status);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_MAX) begin
            $display("rsa_private_exponent_derivation test failed");
            $finish;
        end
    end

    initial begin
        int i, ph;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (i = 0; i < N_DIRECTED; i++)
            send_item(directed[i].e, directed[i].p, directed[i].q,
                      directed[i].known, directed[i].key);
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 77 : (ph == 3) ? 15 : 0;
            recv_stall_pct = (ph == 2) ? 77 : (ph == 3) ? 15 : 0;
            for (i = 0; i < N_RANDOM / 4; i++) begin
                if (i == 30) begin
                    // hold off until the block has drained
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (pending_keys.size() != 0) @(posedge aclk);
                end
                send_random();
            end
        end
        s_valid <= 1'b0;
        recv_stall_pct = 0;
        while (pending_keys.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        $display("Covered %0d results: %0d ok, %0d prime low, %0d exponent range, %0d not coprime",
                 results_seen, n_ok, n_low, n_range, n_copr);
        $display("Idle/stall phases: none, sender 77%%, receiver 77%%, both 15%%; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_keys.size() == 0)
            $display("rsa_private_exponent_derivation test passed");
        else
            $display("rsa_private_exponent_derivation test failed");
        $finish;
    end

endmodule

@@ files.f @@
sv/rsa_ped_pkg.sv
sv/rsa_ped_divider.sv
sv/rsa_private_exponent_derivation.sv
bench/tb.sv
